@@ rtl/psr_pkg.sv @@
package psr_pkg;

    // Filter geometry and phase step
    localparam int TAPS   = 16;
    localparam int PHASES = 160;
    localparam int STEP   = 147;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int CPH_W    = 8;
    localparam int CTAP_W   = 4;
    localparam int FRAC_BITS = 15;

    // Derived widths
    localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PH_W    = $clog2(PHASES + STEP);
    localparam int DEPTH   = PHASES * TAPS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int ACC_W   = PROD_W + TAP_W;

    // Stream packing
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 32;

    // Item kinds carried in s_tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Output saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    // Controls driven from the sequencer into each lane
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             mul_en;
        logic [TAP_W-1:0] mul_tap;
        logic             acc_en;
    } lane_ctrl_t;

endpackage

@@ rtl/psr_coef_mem.sv @@
module psr_coef_mem (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [psr_pkg::ADDR_W-1:0]         wr_addr,
    input  logic signed [psr_pkg::COEF_W-1:0]  wr_data,
    input  logic                               rd_en,
    input  logic [psr_pkg::ADDR_W-1:0]         rd_addr,
    output logic signed [psr_pkg::COEF_W-1:0]  rd_data
);
    import psr_pkg::*;

    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] rd_data_reg;

    // Write one coefficient, read one with a registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/psr_mac_lane.sv @@
module psr_mac_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  psr_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [psr_pkg::SAMPLE_W-1:0]  sample_i,
    input  logic signed [psr_pkg::COEF_W-1:0]    coef_i,
    output logic signed [psr_pkg::SAMPLE_W-1:0]  result_o
);
    import psr_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_reg [TAPS];
    logic signed [SAMPLE_W-1:0] hist_sel;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_shift;

    // Shift the newest sample into the history, oldest drops off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (ctrl.shift) begin
            hist_reg[0] <= sample_i;
            for (int i = 1; i < TAPS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign hist_sel = hist_reg[ctrl.mul_tap];

    // Multiply one tap into a product register, then accumulate the registered product
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= coef_i * hist_sel;
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Floor to integer and saturate to the sample range
    assign acc_shift = acc_reg >>> FRAC_BITS;

    always_comb begin
        if (acc_shift > SAT_HI) begin
            result_o = SAT_HI[SAMPLE_W-1:0];
        end else if (acc_shift < SAT_LO) begin
            result_o = SAT_LO[SAMPLE_W-1:0];
        end else begin
            result_o = acc_shift[SAMPLE_W-1:0];
        end
    end

endmodule

@@ rtl/polyphase_stereo_resampler.sv @@
// Sample item: each result passes tap issue, coefficient read, multiply, accumulate and the
// push state before it lands in the output register; taps go one per cycle through the shared
// coefficient memory read port. A sample item holds the input until its last result (one or
// two) is loaded, including any output stall. Coefficient items are written on acceptance.
// The next item is accepted the cycle after the last result of the current one is loaded.
// Reset clears both histories, sets the phase to PHASES and idles the control; the
// coefficient memory keeps its contents and is not swept.
module polyphase_stereo_resampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left_in[15:0], right_in[31:16], coef_phase[39:32], coef_tap[43:40], coef_value[75:44]
    input  logic [psr_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [psr_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast
);
    import psr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] left_in, right_in;
    logic [CPH_W-1:0]           coef_phase;
    logic [CTAP_W-1:0]          coef_tap;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       s_accept;

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [PH_W-1:0]   phase_sub, phase_add;
    logic              n_reg, n_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              start;
    logic              more;
    logic              out_free;
    logic              push;

    logic              issue_on_reg;
    logic [TAP_W-1:0]  issue_tap_reg;
    logic              issue_last;
    logic              rd_vld_reg, rd_last_reg;
    logic [TAP_W-1:0]  rd_tap_reg;
    logic              prod_vld_reg, prod_last_reg;
    logic              done_reg;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [COEF_W-1:0] coef_rd;

    lane_ctrl_t                 lane_ctrl;
    logic signed [SAMPLE_W-1:0] left_res, right_res;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    // Unpack the input item
    assign left_in    = s_tdata[15:0];
    assign right_in   = s_tdata[31:16];
    assign coef_phase = s_tdata[39:32];
    assign coef_tap   = s_tdata[43:40];
    assign coef_value = s_tdata[75:44];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Coefficient write, out-of-range addresses dropped
    assign wr_en   = s_accept && (s_tuser == REQ_COEF)
                     && (int'(coef_phase) < PHASES) && (int'(coef_tap) < TAPS);
    assign wr_addr = ADDR_W'(int'(coef_phase) * TAPS + int'(coef_tap));
    assign rd_addr = base_reg + ADDR_W'(issue_tap_reg);

    psr_coef_mem u_coef_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (coef_value),
        .rd_en   (issue_on_reg),
        .rd_addr (rd_addr),
        .rd_data (coef_rd)
    );

    // Phase arithmetic: saturating step down per input, step up per output
    assign phase_sub  = (phase_reg >= PH_W'(PHASES)) ? phase_reg - PH_W'(PHASES) : '0;
    assign phase_add  = phase_reg + PH_W'(STEP);
    assign more       = !n_reg && (phase_add < PH_W'(PHASES));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign push       = (state_reg == ST_PUSH) && out_free;
    assign issue_last = (issue_tap_reg == TAP_W'(TAPS - 1));

    // Sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        start      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == REQ_SAMPLE)) begin
                    phase_next = phase_sub;
                    n_next     = 1'b0;
                    base_next  = ADDR_W'(int'(phase_sub) * TAPS);
                    if (phase_sub < PH_W'(PHASES)) begin
                        start      = 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (done_reg) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    phase_next = phase_add;
                    n_next     = 1'b1;
                    base_next  = ADDR_W'(int'(phase_add) * TAPS);
                    if (more) begin
                        start      = 1'b1;
                        state_next = ST_MAC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_W'(PHASES);
            n_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            n_reg     <= n_next;
        end
        base_reg <= base_next;
    end

    // Tap issue and pipeline flags: address, read, multiply, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_on_reg  <= 1'b0;
            issue_tap_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            if (start) begin
                issue_on_reg  <= 1'b1;
                issue_tap_reg <= '0;
            end else if (issue_on_reg) begin
                issue_tap_reg <= issue_tap_reg + 1'b1;
                if (issue_last) begin
                    issue_on_reg <= 1'b0;
                end
            end
            rd_vld_reg    <= issue_on_reg;
            rd_last_reg   <= issue_on_reg && issue_last;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_vld_reg && rd_last_reg;
            done_reg      <= prod_vld_reg && prod_last_reg;
        end
        rd_tap_reg <= issue_tap_reg;
    end

    // Lane controls shared by both channels
    always_comb begin
        lane_ctrl.shift   = s_accept && (s_tuser == REQ_SAMPLE);
        lane_ctrl.clear   = start;
        lane_ctrl.mul_en  = rd_vld_reg;
        lane_ctrl.mul_tap = rd_tap_reg;
        lane_ctrl.acc_en  = prod_vld_reg;
    end

    psr_mac_lane u_lane_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .sample_i (left_in),
        .coef_i   (coef_rd),
        .result_o (left_res)
    );

    psr_mac_lane u_lane_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .sample_i (right_in),
        .coef_i   (coef_rd),
        .result_o (right_res)
    );

    // Merge both lanes into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (push) begin
            m_tdata_reg <= {right_res, left_res};
            m_tlast_reg <= !more;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
